// ===== rtl/drkl_pkg.sv =====
// ============================================================================
// drkl_pkg
// Shared types, key codes and run tables for the dual-role key and layer engine.
// ============================================================================
`default_nettype none

package drkl_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_BASE  = 2'd1;

  localparam logic [14:0] TAP_WINDOW_RESET = 15'd200;
  localparam logic [15:0] CODE_BASE_RESET  = 16'd32320;

  // Offsets of the six dual-role keys from the custom code base.
  localparam logic [15:0] REL_LOWER  = 16'd1;
  localparam logic [15:0] REL_RAISE  = 16'd2;
  localparam logic [15:0] REL_ADJUST = 16'd3;
  localparam logic [15:0] REL_SPACE  = 16'd4;
  localparam logic [15:0] REL_ENTER  = 16'd5;
  localparam logic [15:0] REL_GUIALT = 16'd6;

  // HID usages.
  localparam logic [7:0] HID_INTL5 = 8'h8B;
  localparam logic [7:0] HID_LANG2 = 8'h91;
  localparam logic [7:0] HID_INTL4 = 8'h8A;
  localparam logic [7:0] HID_LANG1 = 8'h90;
  localparam logic [7:0] HID_RSFT  = 8'hE5;
  localparam logic [7:0] HID_RCTL  = 8'hE4;
  localparam logic [7:0] HID_SPC   = 8'h2C;
  localparam logic [7:0] HID_LSFT  = 8'hE1;
  localparam logic [7:0] HID_ENT   = 8'h28;
  localparam logic [7:0] HID_LGUI  = 8'hE3;
  localparam logic [7:0] HID_LALT  = 8'hE2;
  localparam logic [7:0] HID_NONE  = 8'h00;

  // Command queue geometry.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  // Longest run of results for one event, and the step counter width.
  localparam int MAX_STEPS = 10;
  localparam int STEP_W    = $clog2(MAX_STEPS);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_LAYER = 2'd0,
    KIND_DOWN  = 2'd1,
    KIND_UP    = 2'd2,
    KIND_PASS  = 2'd3
  } kind_t;

  // Result runs that the front end can request.
  typedef enum logic [3:0] {
    SEQ_LAYER        = 4'd0,
    SEQ_LOWER_TAP    = 4'd1,
    SEQ_RAISE_TAP    = 4'd2,
    SEQ_SPACE_DOWN   = 4'd3,
    SEQ_SPACE_UP     = 4'd4,
    SEQ_SPACE_UP_TAP = 4'd5,
    SEQ_ENTER_DOWN   = 4'd6,
    SEQ_ENTER_UP     = 4'd7,
    SEQ_ENTER_UP_TAP = 4'd8,
    SEQ_GUI_DOWN     = 4'd9,
    SEQ_ALT_DOWN     = 4'd10,
    SEQ_GUIALT_UP    = 4'd11,
    SEQ_PASS         = 4'd12
  } seq_t;

  // One classified event as it travels from the front end to the back end.
  typedef struct packed {
    seq_t        seq;
    logic [15:0] code;    // original key code, used by pass-through runs
    logic [2:0]  layers;  // layer bits after the event
  } cmd_t;

  // One step of a run.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
    logic       last;
  } step_t;

  function automatic step_t mk_step(kind_t kind, logic [7:0] code, logic last);
    step_t s;
    s.kind = kind;
    s.code = code;
    s.last = last;
    return s;
  endfunction

  // Result item at position idx of a run.
  function automatic step_t run_step(seq_t seq, logic [STEP_W-1:0] idx);
    step_t s;
    s = mk_step(KIND_LAYER, HID_NONE, 1'b1);
    case (seq)
      SEQ_LAYER:      s = mk_step(KIND_LAYER, HID_NONE, 1'b1);
      SEQ_LOWER_TAP: begin
        case (idx)
          4'd0:    s = mk_step(KIND_DOWN, HID_INTL5, 1'b0);
          4'd1:    s = mk_step(KIND_UP,   HID_INTL5, 1'b0);
          4'd2:    s = mk_step(KIND_DOWN, HID_LANG2, 1'b0);
          default: s = mk_step(KIND_UP,   HID_LANG2, 1'b1);
        endcase
      end
      SEQ_RAISE_TAP: begin
        case (idx)
          4'd0:    s = mk_step(KIND_DOWN, HID_INTL4, 1'b0);
          4'd1:    s = mk_step(KIND_UP,   HID_INTL4, 1'b0);
          4'd2:    s = mk_step(KIND_DOWN, HID_LANG1, 1'b0);
          4'd3:    s = mk_step(KIND_UP,   HID_LANG1, 1'b0);
          4'd4:    s = mk_step(KIND_DOWN, HID_RSFT,  1'b0);
          4'd5:    s = mk_step(KIND_DOWN, HID_RCTL,  1'b0);
          4'd6:    s = mk_step(KIND_DOWN, HID_SPC,   1'b0);
          4'd7:    s = mk_step(KIND_UP,   HID_SPC,   1'b0);
          4'd8:    s = mk_step(KIND_UP,   HID_RCTL,  1'b0);
          default: s = mk_step(KIND_UP,   HID_RSFT,  1'b1);
        endcase
      end
      SEQ_SPACE_DOWN: s = mk_step(KIND_DOWN, HID_LSFT, 1'b1);
      SEQ_SPACE_UP:   s = mk_step(KIND_UP,   HID_LSFT, 1'b1);
      SEQ_SPACE_UP_TAP: begin
        case (idx)
          4'd0:    s = mk_step(KIND_UP,   HID_LSFT, 1'b0);
          4'd1:    s = mk_step(KIND_DOWN, HID_SPC,  1'b0);
          default: s = mk_step(KIND_UP,   HID_SPC,  1'b1);
        endcase
      end
      SEQ_ENTER_DOWN: s = mk_step(KIND_DOWN, HID_RSFT, 1'b1);
      SEQ_ENTER_UP:   s = mk_step(KIND_UP,   HID_RSFT, 1'b1);
      SEQ_ENTER_UP_TAP: begin
        case (idx)
          4'd0:    s = mk_step(KIND_UP,   HID_RSFT, 1'b0);
          4'd1:    s = mk_step(KIND_DOWN, HID_ENT,  1'b0);
          default: s = mk_step(KIND_UP,   HID_ENT,  1'b1);
        endcase
      end
      SEQ_GUI_DOWN:   s = mk_step(KIND_DOWN, HID_LGUI, 1'b1);
      SEQ_ALT_DOWN:   s = mk_step(KIND_DOWN, HID_LALT, 1'b1);
      SEQ_GUIALT_UP: begin
        case (idx)
          4'd0:    s = mk_step(KIND_UP, HID_LGUI, 1'b0);
          default: s = mk_step(KIND_UP, HID_LALT, 1'b1);
        endcase
      end
      SEQ_PASS:       s = mk_step(KIND_PASS, HID_NONE, 1'b1);
      default:        s = mk_step(KIND_LAYER, HID_NONE, 1'b1);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/drkl_front.sv =====
// ============================================================================
// drkl_front
// Accepts key events, updates tap and layer state, and queues one command
// per event that names the run of results to send.
// ============================================================================
`default_nettype none

module drkl_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Event input.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [31:0]                      s_tdata,   // key_code, event_stamp
  input  wire logic                             s_tuser,   // is_press
  // Configuration writes.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [drkl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data,
  // Command queue write side.
  input  wire logic                             q_full,
  output logic                                  q_push,
  output drkl_pkg::cmd_t                        q_cmd
);
  import drkl_pkg::*;

  // Configuration registers.
  logic [14:0] tap_window;
  logic [15:0] code_base;

  // Tap and layer state.
  logic        lower_armed, raise_armed, space_armed, enter_armed, first_tap_done;
  logic [15:0] lower_stamp, raise_stamp, space_stamp, enter_stamp, guialt_stamp;
  logic [2:0]  layers;

  logic        lower_armed_next, raise_armed_next, space_armed_next;
  logic        enter_armed_next, first_tap_done_next;
  logic [2:0]  layers_next;
  seq_t        seq;

  logic [15:0] key_code, now, rel, stamp_sel, elapsed;
  logic        press, accept, in_term, in_double_term;
  logic [1:0]  lr_bits;

  assign key_code = s_tdata[15:0];
  assign now      = s_tdata[31:16];
  assign press    = s_tuser;
  assign rel      = key_code - code_base;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_window <= TAP_WINDOW_RESET;
      code_base  <= CODE_BASE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TAP_WINDOW) begin
        tap_window <= cfg_data[14:0];
      end else if (cfg_index == CFG_CODE_BASE) begin
        code_base <= cfg_data;
      end
    end
  end

  // Time since the stored press of the key this event refers to.
  always_comb begin
    case (rel)
      REL_LOWER:  stamp_sel = lower_stamp;
      REL_RAISE:  stamp_sel = raise_stamp;
      REL_SPACE:  stamp_sel = space_stamp;
      REL_ENTER:  stamp_sel = enter_stamp;
      default:    stamp_sel = guialt_stamp;
    endcase
  end

  assign elapsed        = now - stamp_sel;
  assign in_term        = elapsed < {1'b0, tap_window};
  assign in_double_term = {1'b0, elapsed} < {1'b0, tap_window, 1'b0};

  // Classification and next state.
  always_comb begin
    lower_armed_next    = lower_armed;
    raise_armed_next    = raise_armed;
    space_armed_next    = space_armed;
    enter_armed_next    = enter_armed;
    first_tap_done_next = first_tap_done;
    layers_next         = layers;
    lr_bits             = layers[1:0];
    seq                 = SEQ_PASS;
    case (rel)
      REL_LOWER, REL_RAISE: begin
        // Lower and raise also recompute the adjust bit as lower AND raise.
        if (press) begin
          lr_bits = layers[1:0] | rel[1:0];
          seq     = SEQ_LAYER;
          if (rel == REL_LOWER) begin
            lower_armed_next = 1'b1;
          end else begin
            raise_armed_next = 1'b1;
          end
        end else begin
          lr_bits = layers[1:0] & ~rel[1:0];
          if (rel == REL_LOWER) begin
            seq              = (lower_armed && in_term) ? SEQ_LOWER_TAP : SEQ_LAYER;
            lower_armed_next = 1'b0;
          end else begin
            seq              = (raise_armed && in_term) ? SEQ_RAISE_TAP : SEQ_LAYER;
            raise_armed_next = 1'b0;
          end
        end
        layers_next = {&lr_bits, lr_bits};
      end
      REL_ADJUST: begin
        layers_next = {press, layers[1:0]};
        seq         = SEQ_LAYER;
      end
      REL_SPACE: begin
        space_armed_next = press;
        if (press) begin
          seq = SEQ_SPACE_DOWN;
        end else begin
          seq = (space_armed && in_term) ? SEQ_SPACE_UP_TAP : SEQ_SPACE_UP;
        end
      end
      REL_ENTER: begin
        enter_armed_next = press;
        if (press) begin
          seq = SEQ_ENTER_DOWN;
        end else begin
          seq = (enter_armed && in_term) ? SEQ_ENTER_UP_TAP : SEQ_ENTER_UP;
        end
      end
      REL_GUIALT: begin
        // A press soon after a quick tap sends GUI, otherwise ALT.
        if (press) begin
          seq = (first_tap_done && in_double_term) ? SEQ_GUI_DOWN : SEQ_ALT_DOWN;
          first_tap_done_next = 1'b0;
        end else begin
          seq = SEQ_GUIALT_UP;
          if (!first_tap_done && in_term) begin
            first_tap_done_next = 1'b1;
          end
        end
      end
      default: begin
        // Ordinary keys pass through; a press cancels pending taps.
        seq = SEQ_PASS;
        if (press) begin
          lower_armed_next = 1'b0;
          raise_armed_next = 1'b0;
          space_armed_next = 1'b0;
          enter_armed_next = 1'b0;
        end
      end
    endcase
  end

  // State update on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_armed    <= 1'b0;
      raise_armed    <= 1'b0;
      space_armed    <= 1'b0;
      enter_armed    <= 1'b0;
      first_tap_done <= 1'b0;
      layers         <= 3'd0;
      lower_stamp    <= 16'd0;
      raise_stamp    <= 16'd0;
      space_stamp    <= 16'd0;
      enter_stamp    <= 16'd0;
      guialt_stamp   <= 16'd0;
    end else if (accept) begin
      lower_armed    <= lower_armed_next;
      raise_armed    <= raise_armed_next;
      space_armed    <= space_armed_next;
      enter_armed    <= enter_armed_next;
      first_tap_done <= first_tap_done_next;
      layers         <= layers_next;
      if (press && rel == REL_LOWER) begin
        lower_stamp <= now;
      end
      if (press && rel == REL_RAISE) begin
        raise_stamp <= now;
      end
      if (press && rel == REL_SPACE) begin
        space_stamp <= now;
      end
      if (press && rel == REL_ENTER) begin
        enter_stamp <= now;
      end
      if (press && rel == REL_GUIALT) begin
        guialt_stamp <= now;
      end
    end
  end

  // Command toward the back end.
  assign q_push       = accept;
  assign q_cmd.seq    = seq;
  assign q_cmd.code   = key_code;
  assign q_cmd.layers = layers_next;

endmodule

`default_nettype wire

// ===== rtl/drkl_queue.sv =====
// ============================================================================
// drkl_queue
// Short command queue that decouples event intake from result output.
// ============================================================================
`default_nettype none

module drkl_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire drkl_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output drkl_pkg::cmd_t       head_cmd
);
  import drkl_pkg::*;

  cmd_t                entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign full       = count == QCOUNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCOUNT_W'(QDEPTH))
    else $error("queue count above depth");

  // Nothing is taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // Nothing is written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/drkl_back.sv =====
// ============================================================================
// drkl_back
// Expands each queued command into its run of result beats, one per cycle
// while m_tready does not stall it, through a registered output stage.
// ============================================================================
`default_nettype none

module drkl_back (
  input  wire logic           clk,
  input  wire logic           rst,
  // Command queue read side.
  input  wire logic           q_valid,
  input  wire drkl_pkg::cmd_t q_cmd,
  output logic                q_pop,
  // Result output.
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [23:0]         m_tdata,   // out_code, layer_bits, zero pad
  output logic [1:0]          m_tuser,   // action_kind
  output logic                m_tlast    // last_of_run
);
  import drkl_pkg::*;

  logic [STEP_W-1:0] idx;
  step_t             step;
  logic              advance;
  logic [15:0]       code_now;

  kind_t             out_kind;
  logic [15:0]       out_code;
  logic [2:0]        out_layers;

  assign step     = run_step(q_cmd.seq, idx);
  assign advance  = !m_tvalid || m_tready;
  assign q_pop    = advance && q_valid && step.last;
  assign code_now = (q_cmd.seq == SEQ_PASS) ? q_cmd.code : {8'h00, step.code};

  // Step counter within the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (advance && q_valid) begin
      idx <= step.last ? '0 : idx + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      out_kind   <= step.kind;
      out_code   <= code_now;
      out_layers <= q_cmd.layers;
      m_tlast    <= step.last;
    end
  end

  assign m_tdata = {5'd0, out_layers, out_code};
  assign m_tuser = out_kind;

  // The step counter stays inside the longest run.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx < STEP_W'(MAX_STEPS))
    else $error("run step counter out of range");

  // A run in progress keeps its command at the queue head.
  a_run_holds_head: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> q_valid)
    else $error("queue head lost in the middle of a run");

  // Retiring a command always presents the final beat of its run.
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid && m_tlast)
    else $error("command retired without a final beat");

endmodule

`default_nettype wire

// ===== rtl/dual_role_key_layer_engine.sv =====
// ============================================================================
// dual_role_key_layer_engine
// Dual-role key and layer engine: key events in, runs of key and layer
// result beats out.
// ============================================================================
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: key_code[15:0], event_stamp[31:16];
//                                     tuser: is_press
// m_*       out  m_tvalid/m_tready    tdata: out_code[15:0], layer_bits[18:16];
//                                     tuser: action_kind; tlast: last_of_run
// cfg_*     in   cfg_valid/cfg_ready  cfg_index: 0 tap_window, 1 custom_code_base;
//                                     cfg_data
//
// An event is classified and its state updated in the cycle it is accepted.
// Each event yields one to ten result beats, sent one per cycle while m_tready
// does not stall the output; the output beat rate sets the sustained rate.
// A four-entry command queue lets intake run ahead of output until it fills.
// Reset is synchronous; no clearing pass follows. cfg_ready is always high.
// ============================================================================
`default_nettype none

module dual_role_key_layer_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [31:0]                      s_tdata,   // key_code, event_stamp
  input  wire logic                             s_tuser,   // is_press
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [23:0]                           m_tdata,   // out_code, layer_bits
  output logic [1:0]                            m_tuser,   // action_kind
  output logic                                  m_tlast,   // last_of_run
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [drkl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data
);
  import drkl_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic q_full, q_push, q_pop, head_valid;

  // Intake and classification.
  drkl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // Command queue.
  drkl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Result sequencing and output stage.
  drkl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (head_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/key_event_checker.sv =====
// ============================================================================
// key_event_checker
// Watches the key event, result and register channels of the dual-role key
// and layer engine, predicts the result run of every accepted key event and
// compares each result beat, field by field, with the oldest prediction.
// ============================================================================

module key_event_checker
  import drkl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [31:0]            s_tdata,    // key_code, event_stamp
  input  logic                   s_tuser,    // is_press
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [23:0]            m_tdata,    // out_code, layer_bits
  input  logic [1:0]             m_tuser,    // action_kind
  input  logic                   m_tlast,    // last_of_run
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  output int                     fail_count,
  output int                     pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result beat.
  typedef struct {
    kind_t       kind;
    logic [15:0] code;
    logic [2:0]  layers;
    logic        last;
  } report_t;

  report_t pending_reports[$];
  report_t run_reports[$];

  // Shadow of the tapping state and the two registers.
  logic [14:0] tap_window;
  logic [15:0] code_base;
  logic        lower_armed, raise_armed, space_armed, enter_armed, first_tap_done;
  logic [15:0] lower_stamp, raise_stamp, space_stamp, enter_stamp, guialt_stamp;
  logic [2:0]  layers;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic logic [15:0] ticks_since(logic [15:0] now, logic [15:0] then);
    return now - then;
  endfunction

  // Append one beat to the run, never more than the longest run.
  task automatic emit_beat(kind_t kind, logic [15:0] code);
    report_t beat;
    beat.kind   = kind;
    beat.code   = code;
    beat.layers = 3'd0;
    beat.last   = 1'b0;
    if (run_reports.size() < MAX_STEPS) run_reports.push_back(beat);
  endtask

  task automatic emit_usage(kind_t kind, logic [7:0] usage);
    emit_beat(kind, {8'h00, usage});
  endtask

  task automatic tap_usage(logic [7:0] usage);
    emit_usage(KIND_DOWN, usage);
    emit_usage(KIND_UP, usage);
  endtask

  // Update the shadow state for one key event and queue its result run.
  task automatic apply_key_event(logic [15:0] code, logic press, logic [15:0] now);
    logic [15:0] rel;
    logic        layer_evt;
    logic        is_space;
    logic [7:0]  mod_usage;
    logic [7:0]  key_usage;
    int          i;
    rel       = code - code_base;
    layer_evt = 1'b0;
    run_reports.delete();
    case (rel)
      REL_LOWER, REL_RAISE: begin
        layer_evt = 1'b1;
        if (press) begin
          if (rel == REL_LOWER) begin
            lower_armed = 1'b1;
            lower_stamp = now;
          end else begin
            raise_armed = 1'b1;
            raise_stamp = now;
          end
          layers = layers | rel[2:0];
          layers[2] = (layers[1:0] == 2'b11);
        end else begin
          layers = layers & ~rel[2:0];
          layers[2] = (layers[1:0] == 2'b11);
          if (rel == REL_LOWER) begin
            // A quick lower tap sends the first language pair.
            if (lower_armed && ticks_since(now, lower_stamp) < {1'b0, tap_window}) begin
              tap_usage(HID_INTL5);
              tap_usage(HID_LANG2);
            end
            lower_armed = 1'b0;
          end else begin
            // A quick raise tap sends the second pair and a shifted control space.
            if (raise_armed && ticks_since(now, raise_stamp) < {1'b0, tap_window}) begin
              tap_usage(HID_INTL4);
              tap_usage(HID_LANG1);
              emit_usage(KIND_DOWN, HID_RSFT);
              emit_usage(KIND_DOWN, HID_RCTL);
              tap_usage(HID_SPC);
              emit_usage(KIND_UP, HID_RCTL);
              emit_usage(KIND_UP, HID_RSFT);
            end
            raise_armed = 1'b0;
          end
        end
      end
      REL_ADJUST: begin
        layer_evt = 1'b1;
        layers[2] = press;
      end
      REL_SPACE, REL_ENTER: begin
        is_space  = (rel == REL_SPACE);
        mod_usage = is_space ? HID_LSFT : HID_RSFT;
        key_usage = is_space ? HID_SPC : HID_ENT;
        if (press) begin
          if (is_space) begin
            space_armed = 1'b1;
            space_stamp = now;
          end else begin
            enter_armed = 1'b1;
            enter_stamp = now;
          end
          emit_usage(KIND_DOWN, mod_usage);
        end else begin
          emit_usage(KIND_UP, mod_usage);
          if (is_space) begin
            if (space_armed && ticks_since(now, space_stamp) < {1'b0, tap_window})
              tap_usage(key_usage);
            space_armed = 1'b0;
          end else begin
            if (enter_armed && ticks_since(now, enter_stamp) < {1'b0, tap_window})
              tap_usage(key_usage);
            enter_armed = 1'b0;
          end
        end
      end
      REL_GUIALT: begin
        if (press) begin
          // The double term is twice the window and fits in 16 bits.
          if (first_tap_done && ticks_since(now, guialt_stamp) < {tap_window, 1'b0})
            emit_usage(KIND_DOWN, HID_LGUI);
          else
            emit_usage(KIND_DOWN, HID_LALT);
          guialt_stamp   = now;
          first_tap_done = 1'b0;
        end else begin
          if (!first_tap_done && ticks_since(now, guialt_stamp) < {1'b0, tap_window})
            first_tap_done = 1'b1;
          emit_usage(KIND_UP, HID_LGUI);
          emit_usage(KIND_UP, HID_LALT);
        end
      end
      default: begin
        // Any other key passes through, and pressing it cancels pending taps.
        if (press) begin
          lower_armed = 1'b0;
          raise_armed = 1'b0;
          space_armed = 1'b0;
          enter_armed = 1'b0;
        end
        emit_beat(KIND_PASS, code);
      end
    endcase

    if (layer_evt && run_reports.size() == 0) emit_beat(KIND_LAYER, 16'h0000);

    for (i = 0; i < run_reports.size(); i++) begin
      run_reports[i].layers = layers;
      run_reports[i].last   = (i == run_reports.size() - 1);
      pending_reports.push_back(run_reports[i]);
    end
  endtask

  // Compare one result beat with the oldest prediction.
  task automatic check_result_beat();
    report_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t ERROR unexpected result beat: expected none, actual kind %0d code %h layers %0d last %0b",
               $time, m_tuser, m_tdata[15:0], m_tdata[18:16], m_tlast);
      fail_count++;
    end else begin
      want = pending_reports.pop_front();
      if (m_tuser != want.kind) begin
        $display("%0t ERROR action_kind: expected %0d, actual %0d", $time, want.kind, m_tuser);
        fail_count++;
      end
      if (m_tdata[15:0] != want.code) begin
        $display("%0t ERROR out_code: expected %h, actual %h", $time, want.code, m_tdata[15:0]);
        fail_count++;
      end
      if (m_tdata[18:16] != want.layers) begin
        $display("%0t ERROR layer_bits: expected %0d, actual %0d",
                 $time, want.layers, m_tdata[18:16]);
        fail_count++;
      end
      if (m_tlast != want.last) begin
        $display("%0t ERROR last_of_run: expected %0b, actual %0b", $time, want.last, m_tlast);
        fail_count++;
      end
    end
  endtask

  // Beats are taken at the rising edge; results leave before new events enter.
  always @(posedge clk) begin
    if (rst) begin
      tap_window     = TAP_WINDOW_RESET;
      code_base      = CODE_BASE_RESET;
      lower_armed    = 1'b0;
      raise_armed    = 1'b0;
      space_armed    = 1'b0;
      enter_armed    = 1'b0;
      first_tap_done = 1'b0;
      lower_stamp    = 16'd0;
      raise_stamp    = 16'd0;
      space_stamp    = 16'd0;
      enter_stamp    = 16'd0;
      guialt_stamp   = 16'd0;
      layers         = 3'd0;
      pending_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TAP_WINDOW: tap_window = cfg_data[14:0];
          CFG_CODE_BASE:  code_base  = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_result_beat();
      if (s_tvalid && s_tready) apply_key_event(s_tdata[15:0], s_tuser, s_tdata[31:16]);
    end
    pending_count = pending_reports.size();
  end

endmodule

// ===== tb/tb_dual_role_key_layer_engine.sv =====
// ============================================================================
// tb_dual_role_key_layer_engine
// Drives key events and register writes into the dual-role key and layer
// engine: a directed pass over every key role, then random tap, hold, chord
// and double-tap sequences under several register settings and idle mixes.
// ============================================================================

module tb_dual_role_key_layer_engine;

  timeunit 1ns;
  timeprecision 1ps;

  import drkl_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLDOFF_LEN   = 300;
  localparam int HOLDOFF_AFTER = 60;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [31:0]            s_tdata;    // key_code, event_stamp
  logic                   s_tuser;    // is_press
  logic                   m_tvalid;
  logic                   m_tready;
  logic [23:0]            m_tdata;    // out_code, layer_bits
  logic [1:0]             m_tuser;    // action_kind
  logic                   m_tlast;    // last_of_run
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]            cfg_data;

  int          fail_count;
  int          pending_count;
  int          tx_idle_pct = 38;
  int          rx_idle_pct = 61;
  int          events_sent = 0;
  int          accepted_events = 0;
  int          stall_cycles = 0;
  int          tw_cur = TAP_WINDOW_RESET;
  int          base_cur = CODE_BASE_RESET;
  logic [15:0] stamp_now = 16'd0;

  dual_role_key_layer_engine dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  key_event_checker event_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count accepted key events; the receiver hold-off keys off this count.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) accepted_events <= accepted_events + 1;
  end

  // Watchdog: ends the run when no beat of any channel moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off that fills the block.
  initial begin : result_receiver
    logic holdoff_done;
    holdoff_done = 1'b0;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!holdoff_done && accepted_events >= HOLDOFF_AFTER) begin
        holdoff_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLDOFF_LEN) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [15:0] dual_code(int k);
    int v;
    v = base_cur + k;
    return v[15:0];
  endfunction

  function automatic logic [15:0] random_word();
    int v;
    v = $urandom;
    return v[15:0];
  endfunction

  // Time between two events, biased to land around the single and double term.
  function automatic logic [15:0] pick_gap();
    int v;
    case ($urandom_range(6))
      0, 1:    v = (tw_cur > 1) ? $urandom_range(tw_cur - 1, 0) : 0;
      2:       v = tw_cur - 1;
      3:       v = tw_cur;
      4:       v = tw_cur + 1;
      5:       v = 2 * tw_cur - 1 + $urandom_range(2);
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  // Offer one key event beat and wait until it is taken. Called at a falling edge.
  task automatic send_event(logic [15:0] code, logic press, logic [15:0] stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp, code};
    s_tuser  <= press;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic timed_event(logic [15:0] code, logic press);
    stamp_now = stamp_now + pick_gap();
    send_event(code, press, stamp_now);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering events and wait until every predicted result has left.
  task automatic settle_outputs();
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One random sequence of key events; most are well-formed role sequences.
  task automatic play_scenario();
    int          k;
    logic [15:0] other;
    k     = $urandom_range(6, 1);
    other = random_word();
    case ($urandom_range(9))
      0, 1, 2: begin
        // Tap or hold of one dual-role key.
        timed_event(dual_code(k), 1'b1);
        timed_event(dual_code(k), 1'b0);
      end
      3: begin
        // GUI/ALT double tap, inside or outside the double term.
        timed_event(dual_code(REL_GUIALT), 1'b1);
        timed_event(dual_code(REL_GUIALT), 1'b0);
        timed_event(dual_code(REL_GUIALT), 1'b1);
        timed_event(dual_code(REL_GUIALT), 1'b0);
      end
      4: begin
        // Lower and raise chord, released in either order.
        timed_event(dual_code(REL_LOWER), 1'b1);
        timed_event(dual_code(REL_RAISE), 1'b1);
        if ($urandom_range(1)) begin
          timed_event(dual_code(REL_RAISE), 1'b0);
          timed_event(dual_code(REL_LOWER), 1'b0);
        end else begin
          timed_event(dual_code(REL_LOWER), 1'b0);
          timed_event(dual_code(REL_RAISE), 1'b0);
        end
      end
      5: begin
        // Another key pressed while a dual-role key is held.
        timed_event(dual_code(k), 1'b1);
        timed_event(other, 1'b1);
        timed_event(dual_code(k), 1'b0);
        timed_event(other, 1'b0);
      end
      6: begin
        timed_event(dual_code(REL_ADJUST), 1'b1);
        timed_event(dual_code(REL_ADJUST), 1'b0);
      end
      7: begin
        // Noise: any code, any direction, any stamp.
        stamp_now = random_word();
        send_event(other, 1'($urandom_range(1)), stamp_now);
      end
      8: begin
        // Codes just outside the custom range pass through.
        other = $urandom_range(1) ? dual_code(0) : dual_code(7);
        timed_event(other, 1'b1);
        timed_event(other, 1'b0);
      end
      default: begin
        // Release with no matching press.
        timed_event(dual_code(k), 1'b0);
      end
    endcase
  endtask

  task automatic run_segment(int term, int cbase, int tx_pct, int rx_pct, int n_events);
    int target;
    settle_outputs();
    cfg_write(CFG_TAP_WINDOW, term[15:0]);
    cfg_write(CFG_CODE_BASE, cbase[15:0]);
    tw_cur      = term;
    base_cur    = cbase;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target      = events_sent + n_events;
    while (events_sent < target) play_scenario();
  endtask

  // Main stimulus and verdict.
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 32'd0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TAP_WINDOW;
    cfg_data  = 16'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass at the reset settings.
    // A lower tap, then a raise tap one tick inside the term.
    send_event(dual_code(REL_LOWER), 1'b1, 16'd100);
    send_event(dual_code(REL_LOWER), 1'b0, 16'd150);
    send_event(dual_code(REL_RAISE), 1'b1, 16'd200);
    send_event(dual_code(REL_RAISE), 1'b0, 16'd399);
    // Tri-layer chord held past the term, so no taps.
    send_event(dual_code(REL_LOWER), 1'b1, 16'd1000);
    send_event(dual_code(REL_RAISE), 1'b1, 16'd1010);
    send_event(dual_code(REL_RAISE), 1'b0, 16'd1300);
    send_event(dual_code(REL_LOWER), 1'b0, 16'd1305);
    send_event(dual_code(REL_ADJUST), 1'b1, 16'd1400);
    send_event(dual_code(REL_ADJUST), 1'b0, 16'd1410);
    // Space tap, then a hold of exactly the term.
    send_event(dual_code(REL_SPACE), 1'b1, 16'd2000);
    send_event(dual_code(REL_SPACE), 1'b0, 16'd2100);
    send_event(dual_code(REL_SPACE), 1'b1, 16'd3000);
    send_event(dual_code(REL_SPACE), 1'b0, 16'd3200);
    // Enter tap across the stamp wrap.
    send_event(dual_code(REL_ENTER), 1'b1, 16'hFFFF);
    send_event(dual_code(REL_ENTER), 1'b0, 16'd85);
    // ALT on the first press, GUI on a second press within the double term.
    send_event(dual_code(REL_GUIALT), 1'b1, 16'd4000);
    send_event(dual_code(REL_GUIALT), 1'b0, 16'd4050);
    send_event(dual_code(REL_GUIALT), 1'b1, 16'd4300);
    send_event(dual_code(REL_GUIALT), 1'b0, 16'd4310);
    // A pass-through press cancels the space tap; code extremes and the base code.
    send_event(dual_code(REL_SPACE), 1'b1, 16'd5000);
    send_event(16'hFFFF, 1'b1, 16'd5010);
    send_event(dual_code(REL_SPACE), 1'b0, 16'd5020);
    send_event(16'h0000, 1'b0, 16'h0000);
    send_event(dual_code(0), 1'b1, 16'hFFFF);

    // Random sequences under several settings and idle mixes.
    run_segment($urandom_range(400, 20), $urandom_range(65535), 38, 61, 50);
    run_segment(0, 0, 38, 61, 15);
    run_segment(32767, 65535, 61, 38, 40);
    run_segment(1, 65532, 0, 0, 15);
    run_segment($urandom_range(300, 2), CODE_BASE_RESET, 0, 0, 45);

    settle_outputs();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
